// File: src/qlbs_pkg.sv
// qlbs_pkg: shared constants and types for the queued led blink sequencer
// no dependencies; imported by qlbs_player and the top level
`default_nettype none

package qlbs_pkg;

    // item opcodes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // fixed field widths
    localparam int BLINK_W  = 16;
    localparam int FIELD_W  = 16;
    localparam int QCOUNT_W = 4;

    // parameter defaults
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_TIME_WIDTH  = 16;

    // control from the sequencer to the player
    typedef struct packed {
        logic tick;   // any accepted tick transaction
        logic start;  // tick that takes the head request
        logic fill;   // head request read data is valid
    } qlbs_play_ctl_t;

    // player state after the current transaction
    typedef struct packed {
        logic active;
        logic led;
    } qlbs_play_sts_t;

endpackage

`default_nettype wire

// File: src/qlbs_mem.sv
// qlbs_mem: request store, one write port and one registered read port
// depends on nothing outside this file
`default_nettype none

module qlbs_mem #(
    parameter int DEPTH  = 8,
    parameter int DATA_W = 48,
    parameter int ADDR_W = 3
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/qlbs_player.sv
// qlbs_player: active request, blink and phase counters, led level
// depends on qlbs_pkg; request data comes from qlbs_mem
`default_nettype none

module qlbs_player
    import qlbs_pkg::*;
#(
    parameter int TIME_WIDTH = DEF_TIME_WIDTH,
    parameter int REQ_W      = BLINK_W + 2 * TIME_WIDTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire qlbs_play_ctl_t ctl,
    input  wire logic [REQ_W-1:0] req_data,
    output qlbs_play_sts_t      sts_next
);

    logic                  active_reg, active_next;
    logic                  led_reg, led_next;
    logic [BLINK_W-1:0]    blinks_reg;
    logic [TIME_WIDTH-1:0] on_t_reg, off_t_reg;
    logic [BLINK_W-1:0]    done_reg, done_next;
    logic [TIME_WIDTH-1:0] on_el_reg, on_el_next;
    logic [TIME_WIDTH-1:0] off_el_reg, off_el_next;

    always_comb begin
        active_next = active_reg;
        led_next    = led_reg;
        done_next   = done_reg;
        on_el_next  = on_el_reg;
        off_el_next = off_el_reg;
        if (ctl.start) begin
            active_next = 1'b1;
            done_next   = '0;
            on_el_next  = '0;
            off_el_next = '0;
        end else if (ctl.tick && active_reg) begin
            if (done_reg < blinks_reg) begin
                if (on_el_reg < on_t_reg) begin
                    led_next   = 1'b1;
                    on_el_next = on_el_reg + 1'b1;
                end
                // off phase may run in the same tick once on is complete
                if (on_el_next >= on_t_reg && off_el_reg < off_t_reg) begin
                    led_next    = 1'b0;
                    off_el_next = off_el_reg + 1'b1;
                end
                if (off_el_next >= off_t_reg && on_el_next >= on_t_reg) begin
                    done_next   = done_reg + 1'b1;
                    on_el_next  = '0;
                    off_el_next = '0;
                end
            end else begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            led_reg    <= 1'b0;
            done_reg   <= '0;
            on_el_reg  <= '0;
            off_el_reg <= '0;
        end else begin
            active_reg <= active_next;
            led_reg    <= led_next;
            done_reg   <= done_next;
            on_el_reg  <= on_el_next;
            off_el_reg <= off_el_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.fill) begin
            {blinks_reg, on_t_reg, off_t_reg} <= req_data;
        end
    end

    assign sts_next.active = active_next;
    assign sts_next.led    = led_next;

endmodule

`default_nettype wire

// File: src/queued_led_blink_sequencer.sv
// queued_led_blink_sequencer: request queue pointers, handshake and result register
// depends on qlbs_pkg, qlbs_mem and qlbs_player
//
//   channel  | ports                                        | direction
//   ---------+----------------------------------------------+----------
//   s_       | s_op, s_blink_count, s_on_ticks, s_off_ticks | in
//   m_       | m_led_level, m_busy_res, m_queue_count,      | out
//            | m_request_dropped                            |
//
// a tick that takes the head request moves the block into a fetch state, in which
// s_ready is low while the request store's registered read port returns that request.
// one result per transaction, held in an output register; outside a fetch,
// a new transaction is taken while that register is empty or being drained
// in the same cycle. reset (aresetn, synchronous) empties the queue, stops
// playback, led off; the store itself is not cleared and needs no clearing pass.
`default_nettype none

module queued_led_blink_sequencer
    import qlbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TIME_WIDTH  = DEF_TIME_WIDTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_op,
    input  wire logic [BLINK_W-1:0]  s_blink_count,
    input  wire logic [FIELD_W-1:0]  s_on_ticks,
    input  wire logic [FIELD_W-1:0]  s_off_ticks,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_led_level,
    output logic                     m_busy_res,
    output logic [QCOUNT_W-1:0]      m_queue_count,
    output logic                     m_request_dropped
);

    localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int REQ_W = BLINK_W + 2 * TIME_WIDTH;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_FETCH = 1'b1;

    logic state_reg, state_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic                m_valid_reg;
    logic                m_led_reg;
    logic                m_busy_reg;
    logic [QCOUNT_W-1:0] m_qcount_reg;
    logic                m_drop_reg;

    logic accept, is_enq, is_tick, full, take, store;
    logic [TIME_WIDTH+FIELD_W-1:0] on_ext, off_ext;
    logic [REQ_W-1:0]              wr_data, rd_data;
    logic [CW+QCOUNT_W-1:0]        cnt_ext;
    qlbs_play_ctl_t ctl;
    qlbs_play_sts_t sts_next;
    logic player_active_reg;

    assign s_ready = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign is_enq  = accept && (s_op == OP_ENQUEUE);
    assign is_tick = accept && (s_op == OP_TICK);
    assign full    = (cnt_reg >= CW'(QUEUE_DEPTH));
    assign store   = is_enq && !full;
    // idle tick with a waiting request dequeues it
    assign take    = is_tick && !player_active_reg && (cnt_reg != '0);

    // time fields masked to TIME_WIDTH bits
    assign on_ext  = {{TIME_WIDTH{1'b0}}, s_on_ticks};
    assign off_ext = {{TIME_WIDTH{1'b0}}, s_off_ticks};
    assign wr_data = {s_blink_count, on_ext[TIME_WIDTH-1:0], off_ext[TIME_WIDTH-1:0]};

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        state_next  = state_reg;
        if (store) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            cnt_next    = cnt_reg + 1'b1;
        end
        if (take) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            cnt_next    = cnt_reg - 1'b1;
        end
        unique case (state_reg)
            ST_RUN:   if (take) begin
                state_next = ST_FETCH;
            end
            ST_FETCH: state_next = ST_RUN;
            default:  state_next = ST_RUN;
        endcase
    end

    assign ctl.tick  = is_tick;
    assign ctl.start = take;
    assign ctl.fill  = (state_reg == ST_FETCH);

    assign cnt_ext = {{QCOUNT_W{1'b0}}, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_RUN;
            rd_ptr_reg        <= '0;
            wr_ptr_reg        <= '0;
            cnt_reg           <= '0;
            m_valid_reg       <= 1'b0;
            player_active_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
            if (accept) begin
                m_valid_reg       <= 1'b1;
                player_active_reg <= sts_next.active;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload loads with the transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_led_reg    <= sts_next.led;
            m_busy_reg   <= sts_next.active;
            m_qcount_reg <= cnt_ext[QCOUNT_W-1:0];
            m_drop_reg   <= is_enq && full;
        end
    end

    qlbs_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (REQ_W),
        .ADDR_W (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (store),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_data),
        .rd_en   (take),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    qlbs_player #(
        .TIME_WIDTH (TIME_WIDTH),
        .REQ_W      (REQ_W)
    ) u_player (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .req_data (rd_data),
        .sts_next (sts_next)
    );

    assign m_valid           = m_valid_reg;
    assign m_led_level       = m_led_reg;
    assign m_busy_res        = m_busy_reg;
    assign m_queue_count     = m_qcount_reg;
    assign m_request_dropped = m_drop_reg;

endmodule

`default_nettype wire

// File: sim/tb_queued_led_blink_sequencer.sv
// testbench for queued_led_blink_sequencer: directed rows, then random enqueue/tick traffic; typed rows
// checked against their given results, the rest against an in-bench model of the request queue and led player
// depends on qlbs_pkg and the queued_led_blink_sequencer rtl
`timescale 1ns / 1ps

module tb_queued_led_blink_sequencer
    import qlbs_pkg::*;
;

    localparam int DEPTH        = DEF_QUEUE_DEPTH;
    localparam int DIRECTED_CNT = 25;
    localparam int RANDOM_CNT   = 700;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic                led;
        logic                busy;
        logic [QCOUNT_W-1:0] qcount;
        logic                dropped;
    } led_result_t;

    typedef struct packed {
        logic [BLINK_W-1:0] blinks;
        logic [FIELD_W-1:0] on_t;
        logic [FIELD_W-1:0] off_t;
    } blink_req_t;

    typedef struct packed {
        logic               op;
        logic [BLINK_W-1:0] blinks;
        logic [FIELD_W-1:0] on_t;
        logic [FIELD_W-1:0] off_t;
        logic               typed;
        led_result_t        want;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_op;
    logic [BLINK_W-1:0]   s_blink_count;
    logic [FIELD_W-1:0]   s_on_ticks;
    logic [FIELD_W-1:0]   s_off_ticks;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_led_level;
    logic                 m_busy_res;
    logic [QCOUNT_W-1:0]  m_queue_count;
    logic                 m_request_dropped;

    // model of the queue and the player
    blink_req_t  req_store [DEPTH];
    int          rd_ptr;
    int          wr_ptr;
    int          queued;
    bit          playing;
    blink_req_t  cur_req;
    int          blinks_done;
    int          on_elapsed;
    int          off_elapsed;
    logic        led_on;

    led_result_t pending_led_results[$];
    stim_row_t   directed_rows [DIRECTED_CNT];
    int          mismatches;
    bit          quiet;
    int          rx_stall;

    queued_led_blink_sequencer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_blink_count     (s_blink_count),
        .s_on_ticks        (s_on_ticks),
        .s_off_ticks       (s_off_ticks),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_led_level       (m_led_level),
        .m_busy_res        (m_busy_res),
        .m_queue_count     (m_queue_count),
        .m_request_dropped (m_request_dropped)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic led_result_t predict_led_result(input logic op, input blink_req_t req);
        led_result_t res;
        res.dropped = 1'b0;
        if (op == OP_ENQUEUE) begin
            if (queued >= DEPTH) begin
                res.dropped = 1'b1;
            end else begin
                req_store[wr_ptr] = req;
                wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
                queued++;
            end
        end else if (!playing) begin
            if (queued != 0) begin
                cur_req = req_store[rd_ptr];
                rd_ptr = (rd_ptr + 1 >= DEPTH) ? 0 : rd_ptr + 1;
                queued--;
                playing = 1'b1;
                blinks_done = 0;
                on_elapsed = 0;
                off_elapsed = 0;
            end
        end else if (blinks_done < cur_req.blinks) begin
            if (on_elapsed < cur_req.on_t) begin
                led_on = 1'b1;
                on_elapsed++;
            end
            // off phase may run in the same tick that completes the on phase
            if (on_elapsed >= cur_req.on_t && off_elapsed < cur_req.off_t) begin
                led_on = 1'b0;
                off_elapsed++;
            end
            if (off_elapsed >= cur_req.off_t && on_elapsed >= cur_req.on_t) begin
                blinks_done++;
                on_elapsed = 0;
                off_elapsed = 0;
            end
        end else begin
            playing = 1'b0;
        end
        res.led    = led_on;
        res.busy   = playing;
        res.qcount = queued[QCOUNT_W-1:0];
        return res;
    endfunction

    function automatic stim_row_t row(input logic op, input int b, input int on, input int off,
                                      input bit typed, input led_result_t want);
        stim_row_t r;
        r.op     = op;
        r.blinks = b[BLINK_W-1:0];
        r.on_t   = on[FIELD_W-1:0];
        r.off_t  = off[FIELD_W-1:0];
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // drive one transaction, hold it until taken, then record what it should produce
    task automatic send_item(input logic op, input blink_req_t req, input bit typed,
                             input led_result_t want);
        led_result_t model_res;
        int          gap;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_op          <= op;
        s_blink_count <= req.blinks;
        s_on_ticks    <= req.on_t;
        s_off_ticks   <= req.off_t;
        do @(posedge aclk); while (!(s_valid && s_ready));
        model_res = predict_led_result(op, req);
        pending_led_results.push_back(typed ? want : model_res);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_led_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // result side: random backpressure
    initial begin
        m_ready  = 1'b0;
        rx_stall = 0;
        forever begin
            @(negedge aclk);
            if (rx_stall > 0) begin
                m_ready <= 1'b0;
                rx_stall--;
            end else begin
                m_ready <= 1'b1;
                rx_stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : result_check
        led_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_led_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: led=%0b busy=%0b qcount=%0d dropped=%0b",
                             m_led_level, m_busy_res, m_queue_count, m_request_dropped);
            end else begin
                want = pending_led_results.pop_front();
                if (m_led_level !== want.led || m_busy_res !== want.busy ||
                    m_queue_count !== want.qcount || m_request_dropped !== want.dropped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: led %0b/%0b busy %0b/%0b ",
                                  "qcount %0d/%0d dropped %0b/%0b (exp/got)"},
                                 $realtime, want.led, m_led_level, want.busy, m_busy_res,
                                 want.qcount, m_queue_count, want.dropped, m_request_dropped);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb_queued_led_blink_sequencer NOT OK");
        $finish;
    end

    initial begin : stimulus
        blink_req_t  req;
        led_result_t none;
        logic        op;
        none = '0;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = OP_TICK;
        s_blink_count = '0;
        s_on_ticks    = '0;
        s_off_ticks   = '0;
        mismatches    = 0;
        quiet         = 1'b0;
        rd_ptr        = 0;
        wr_ptr        = 0;
        queued        = 0;
        playing       = 1'b0;
        cur_req       = '0;
        blinks_done   = 0;
        on_elapsed    = 0;
        off_elapsed   = 0;
        led_on        = 1'b0;

        // tick on an empty idle block, zero blink request, queue fill and overflow
        directed_rows[0]  = row(OP_TICK,    0,      0,      0,      1, '{1'b0, 1'b0, 4'd0, 1'b0});
        directed_rows[1]  = row(OP_ENQUEUE, 0,      0,      0,      1, '{1'b0, 1'b0, 4'd1, 1'b0});
        directed_rows[2]  = row(OP_TICK,    0,      0,      0,      1, '{1'b0, 1'b1, 4'd0, 1'b0});
        directed_rows[3]  = row(OP_TICK,    0,      0,      0,      1, '{1'b0, 1'b0, 4'd0, 1'b0});
        directed_rows[4]  = row(OP_ENQUEUE, 1,      0,      0,      0, none);
        directed_rows[5]  = row(OP_ENQUEUE, 1,      0,      2,      0, none);
        directed_rows[6]  = row(OP_ENQUEUE, 1,      2,      1,      0, none);
        directed_rows[7]  = row(OP_ENQUEUE, 2,      1,      0,      0, none);
        directed_rows[8]  = row(OP_ENQUEUE, 1,      1,      1,      0, none);
        directed_rows[9]  = row(OP_ENQUEUE, 3,      0,      0,      0, none);
        directed_rows[10] = row(OP_ENQUEUE, 1,      3,      0,      0, none);
        directed_rows[11] = row(OP_ENQUEUE, 2,      1,      2,      1, '{1'b0, 1'b0, 4'd8, 1'b0});
        directed_rows[12] = row(OP_ENQUEUE, 'hFFFF, 'hFFFF, 'hFFFF, 1, '{1'b0, 1'b0, 4'd8, 1'b1});
        directed_rows[13] = row(OP_ENQUEUE, 'hAAAA, 'h5555, 'hAAAA, 1, '{1'b0, 1'b0, 4'd8, 1'b1});
        directed_rows[14] = row(OP_ENQUEUE, 'h5555, 'hAAAA, 'h5555, 1, '{1'b0, 1'b0, 4'd8, 1'b1});
        directed_rows[15] = row(OP_TICK,    'hFFFF, 'hFFFF, 'hFFFF, 1, '{1'b0, 1'b1, 4'd7, 1'b0});
        for (int i = 16; i < DIRECTED_CNT; i++)
            directed_rows[i] = row(OP_TICK, 0, 0, 0, 0, none);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            req.blinks = directed_rows[i].blinks;
            req.on_t   = directed_rows[i].on_t;
            req.off_t  = directed_rows[i].off_t;
            send_item(directed_rows[i].op, req, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int n = 0; n < RANDOM_CNT; n++) begin
            if (n % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_CNT / 2 || $urandom_range(0, 149) == 0)
                hold_until_drained();
            op = ($urandom_range(0, 99) < 30) ? OP_ENQUEUE : OP_TICK;
            if (op == OP_ENQUEUE && queued < DEPTH) begin
                // playable request, kept short so the queue keeps moving
                req.blinks = BLINK_W'($urandom_range(0, 3));
                if ($urandom_range(0, 19) == 0) begin
                    req.on_t  = FIELD_W'($urandom_range(0, 30));
                    req.off_t = FIELD_W'($urandom_range(0, 30));
                end else begin
                    req.on_t  = FIELD_W'($urandom_range(0, 4));
                    req.off_t = FIELD_W'($urandom_range(0, 4));
                end
            end else begin
                // ticks and dropped enqueues ignore the fields, so use the full width
                req.blinks = BLINK_W'($urandom);
                req.on_t   = FIELD_W'($urandom);
                req.off_t  = FIELD_W'($urandom);
            end
            send_item(op, req, 1'b0, none);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_led_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("tb_queued_led_blink_sequencer OK");
        else
            $display("tb_queued_led_blink_sequencer NOT OK");
        $finish;
    end

endmodule
